>>> sv/assert_macros.svh
// Assertion macros used by the checker file asp_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> sv/asp_pkg.sv
// Package: widths, constants and controller/datapath interface types.
`timescale 1ns / 1ps
package asp_pkg;

  localparam int VALUE_WIDTH = 20;
  localparam int IN_W        = 20;
  localparam int LIMIT_W     = 20;
  localparam int COUNT_OUT_W = 8;
  localparam int SUM_OUT_W   = 23;

  // Operand of one divisor search: input number or partner (partner <= limit).
  localparam int OP_W  = (VALUE_WIDTH > LIMIT_W) ? VALUE_WIDTH : LIMIT_W;
  // Trial divisor runs up to floor(sqrt(m)) + 1.
  localparam int D_W   = (OP_W + 1) / 2 + 1;
  localparam int P_W   = 2 * D_W;
  localparam int SUM_W = OP_W + 3;
  localparam int CNT_W = OP_W / 2 + 2;
  localparam int DC_W  = $clog2(OP_W + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  typedef struct packed {
    logic load_n;     // capture n, start first search
    logic save1;      // keep first search results
    logic load_s;     // start second search on the aliquot sum
    logic sq;         // register d*d
    logic div_start;  // launch m / d
    logic acc;        // fold divisor pair, step d
    logic out_load;   // fill output register
  } asp_cmd_t;

  typedef struct packed {
    logic sq_le;      // d*d <= m
    logic div_done;   // quotient and remainder ready
    logic pair_ok;    // partner search worth running
  } asp_stat_t;

endpackage

>>> sv/asp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module asp_div
  import asp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] dividend,
  input  logic [D_W-1:0]  divisor,
  output logic            done,
  output logic [OP_W-1:0] quot,
  output logic [D_W-1:0]  rem
);

  logic [OP_W-1:0] quo_r;
  logic [D_W-1:0]  rem_r;
  logic [D_W-1:0]  dsr_r;
  logic [DC_W-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [D_W:0]    trial;
  logic [D_W:0]    diff;
  logic            take;

  assign trial = {rem_r, quo_r[OP_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign take  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DC_W'(OP_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[OP_W-2:0], take};
      rem_r <= take ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

>>> sv/asp_dp.sv
// Datapath: trial divisor, square, divider, sums, counts and output register.
`timescale 1ns / 1ps
module asp_dp
  import asp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  asp_cmd_t               cmd,
  output asp_stat_t              stat,
  input  logic [IN_W-1:0]        number_in,
  input  logic [LIMIT_W-1:0]     limit,
  output logic [COUNT_OUT_W-1:0] divisor_count,
  output logic [SUM_OUT_W-1:0]   divisor_sum,
  output logic                   is_perfect,
  output logic                   is_amicable
);

  logic [IN_W+VALUE_WIDTH-1:0] n_ext;
  logic [OP_W-1:0]  n_r, m_r;
  logic [D_W-1:0]   d_r;
  logic [P_W-1:0]   prod_r;
  logic [SUM_W-1:0] sum_r, sum1_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt1_r, cnt_nxt;
  logic             amic_run_r;
  logic             div_done;
  logic [OP_W-1:0]  quot;
  logic [D_W-1:0]   rem;
  logic [OP_W-1:0]  d_op;
  logic             n_ge2;

  logic [COUNT_OUT_W-1:0] count_out_r;
  logic [SUM_OUT_W-1:0]   sum_out_r;
  logic                   perf_out_r, amic_out_r;

  assign n_ext = {{VALUE_WIDTH{1'b0}}, number_in};
  assign d_op  = OP_W'(d_r);
  assign n_ge2 = |n_r[OP_W-1:1];

  asp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (m_r),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // Fold in d and m/d when d divides m, each only if below m, and m/d only if it differs from d.
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (rem == '0) begin
      if (d_op < m_r) begin
        sum_nxt = sum_nxt + SUM_W'(d_r);
        cnt_nxt = cnt_nxt + 1'b1;
      end
      if (quot != d_op && quot < m_r) begin
        sum_nxt = sum_nxt + SUM_W'(quot);
        cnt_nxt = cnt_nxt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amic_run_r <= 1'b0;
    end else if (cmd.load_n) begin
      amic_run_r <= 1'b0;
    end else if (cmd.load_s) begin
      amic_run_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n_r   <= OP_W'(n_ext[VALUE_WIDTH-1:0]);
      m_r   <= OP_W'(n_ext[VALUE_WIDTH-1:0]);
      d_r   <= D_W'(1);
      sum_r <= '0;
      cnt_r <= '0;
    end else if (cmd.load_s) begin
      m_r   <= sum_r[OP_W-1:0];
      d_r   <= D_W'(1);
      sum_r <= '0;
      cnt_r <= '0;
    end else if (cmd.acc) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      d_r   <= d_r + 1'b1;
    end
    if (cmd.save1) begin
      sum1_r <= sum_r;
      cnt1_r <= cnt_r;
    end
    if (cmd.sq) begin
      prod_r <= d_r * d_r;
    end
    if (cmd.out_load) begin
      count_out_r <= (|cnt1_r[CNT_W-1:COUNT_OUT_W]) ? {COUNT_OUT_W{1'b1}}
                                                     : cnt1_r[COUNT_OUT_W-1:0];
      sum_out_r   <= (|sum1_r[SUM_W-1:SUM_OUT_W]) ? {SUM_OUT_W{1'b1}}
                                                   : sum1_r[SUM_OUT_W-1:0];
      perf_out_r  <= n_ge2 && (sum1_r == SUM_W'(n_r));
      amic_out_r  <= amic_run_r && (sum_r == SUM_W'(n_r));
    end
  end

  assign stat.sq_le    = (prod_r <= P_W'(m_r));
  assign stat.div_done = div_done;
  assign stat.pair_ok  = n_ge2 && (sum_r <= SUM_W'(limit)) && (sum_r != SUM_W'(n_r));

  assign divisor_count = count_out_r;
  assign divisor_sum   = sum_out_r;
  assign is_perfect    = perf_out_r;
  assign is_amicable   = amic_out_r;

endmodule

>>> sv/asp_ctrl.sv
// Controller: sequences the two divisor searches and the output handshake.
`timescale 1ns / 1ps
module asp_ctrl
  import asp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output asp_cmd_t  cmd,
  input  asp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_CMP, S_DIV, S_ACC, S_PASS, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_n = 1'b1;
          pass_nxt   = 1'b0;
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.sq_le) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_PASS;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_SQ;
      end
      S_PASS: begin
        if (!pass_r) begin
          cmd.save1 = 1'b1;
          if (stat.pair_ok) begin
            cmd.load_s = 1'b1;
            pass_nxt   = 1'b1;
            state_nxt  = S_SQ;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sv/aliquot_sum_perfect_amicable.sv
// Top level: aliquot sum, perfect-number and amicable-pair test.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_ready carries one number in_number_in per
//   transfer. Result channel out_valid/out_ready returns one transfer per
//   input: proper-divisor count, aliquot sum s (both saturating), a perfect
//   flag, and an amicable flag (s <= limit, s != n, aliquot sum of s is n).
//   Config channel cfg_valid/cfg_ready writes cfg_amicable_limit; cfg_ready
//   is always high. Write it only while the block is idle.
// Operation:
//   One item is worked at a time. Each trial divisor d takes the square,
//   the compare, the bit-serial division in the divider and the fold;
//   the search stops at the first d with d*d > m. A partner search on s
//   follows when n >= 2, s <= limit and s != n. The next input can be
//   taken once the result is in the output register. Both searches use
//   the one shared divider.
// Reset and stall:
//   Synchronous active-low reset idles the controller, drops out_valid and
//   sets the limit to all ones. The output register holds a result while
//   the receiver stalls; the next input is accepted meanwhile and its
//   search runs, waiting only at the end for the register to free up.
module aliquot_sum_perfect_amicable
  import asp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [IN_W-1:0]        in_number_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COUNT_OUT_W-1:0] out_divisor_count,
  output logic [SUM_OUT_W-1:0]   out_divisor_sum,
  output logic                   out_is_perfect,
  output logic                   out_is_amicable,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LIMIT_W-1:0]     cfg_amicable_limit
);

  asp_cmd_t         cmd;
  asp_stat_t        stat;
  logic [LIMIT_W-1:0] limit_r;

  // Partner limit register, loaded from cfg_amicable_limit on cfg_valid; cfg_ready is tied high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_amicable_limit;
    end
  end

  assign cfg_ready = 1'b1;

  asp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  asp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .number_in     (in_number_in),
    .limit         (limit_r),
    .divisor_count (out_divisor_count),
    .divisor_sum   (out_divisor_sum),
    .is_perfect    (out_is_perfect),
    .is_amicable   (out_is_amicable)
  );

endmodule

>>> sv/asp_check.sv
// Port-level checker for the aliquot block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module asp_check
  import asp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COUNT_OUT_W-1:0] out_divisor_count,
  input logic [SUM_OUT_W-1:0]   out_divisor_sum,
  input logic                   out_is_perfect,
  input logic                   out_is_amicable
);

  // A stalled result holds.
  `ASP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(out_divisor_sum) && $stable(out_divisor_count))
  // After an input is taken, in_ready is low in the next cycle.
  `ASP_ASSERT_NXT(a_in_busy, in_valid && in_ready, !in_ready)
  // Perfect needs s == n, amicable needs s != n.
  `ASP_ASSERT_IMP(a_flags_excl, out_valid, !(out_is_perfect && out_is_amicable))
  // No divisors counted exactly when the sum is zero.
  `ASP_ASSERT_IMP(a_cnt_sum, out_valid,
                  (out_divisor_count == '0) == (out_divisor_sum == '0))

endmodule

bind aliquot_sum_perfect_amicable asp_check u_asp_check (.*);
